### rtl/bqe_pkg.sv
// Shared types, widths and corner table for the billboard quad expander.
`timescale 1ns / 1ps

package bqe_pkg;

    // Configuration words
    localparam int NUM_WORDS      = 8;
    localparam int CFG_W          = 63;
    localparam int CFG_IDX_W      = 4;
    localparam int WORD_IDX_W     = 3;
    localparam int COEF_W         = 21;
    localparam int SLOTS_PER_WORD = 3;
    localparam int NUM_SLOTS      = 22;
    localparam int MAT_SLOTS      = 16;
    localparam int RIGHT_SLOT     = 16;
    localparam int UP_SLOT        = 19;

    // Datapath widths
    localparam int POS_W      = 32;
    localparam int COLOR_W    = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int W_SHIFT    = 4;
    localparam int PROD_W     = COEF_W + POS_W;
    localparam int TERM_W     = 40;
    localparam int WORLD_W    = 41;
    localparam int MPROD_W    = COEF_W + WORLD_W;
    localparam int MTERM_W    = MPROD_W - FRAC_SHIFT;
    localparam int SUM_W      = MTERM_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Corner sequencing
    localparam int CORNERS  = 6;
    localparam int CORNER_W = 3;
    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);

    typedef logic [COEF_W-1:0]  coef_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [TERM_W-1:0]  term_t;

    typedef struct packed {
        coef_t [MAT_SLOTS-1:0] mat;
        coef_t [2:0]           right;
        coef_t [2:0]           up;
    } coef_set_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] opacity;
        logic               additive;
    } color_t;

    typedef struct packed {
        pos_t  [2:0] pos;
        term_t [2:0] right_pos;
        term_t [2:0] right_neg;
        term_t [2:0] up_pos;
        term_t [2:0] up_neg;
        color_t      color;
    } quad_t;

    // Corner signs {v, u}: bit set means +1
    function automatic logic [1:0] corner_code(input logic [CORNER_W-1:0] k);
        logic [1:0] code;
        unique case (k)
            3'd0:    code = 2'b00;
            3'd1:    code = 2'b01;
            3'd2:    code = 2'b11;
            3'd3:    code = 2'b00;
            3'd4:    code = 2'b11;
            3'd5:    code = 2'b10;
            default: code = 2'b00;
        endcase
        return code;
    endfunction

endpackage

### rtl/bqe_front.sv
// Front end: accepts particles, drops invisible ones, builds the camera axis offsets.
`timescale 1ns / 1ps

module bqe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          pos_z,
    input  logic signed [31:0]          quad_size,
    input  logic [15:0]                 red,
    input  logic [15:0]                 green,
    input  logic [15:0]                 blue,
    input  logic [15:0]                 opacity,
    input  logic                        additive,
    input  bqe_pkg::coef_set_t          coefs,
    input  logic                        q_full,
    output logic                        q_push,
    output bqe_pkg::quad_t              q_data
);

    logic                                   f1_valid_reg;
    bqe_pkg::pos_t [2:0]                    f1_pos_reg;
    logic [bqe_pkg::POS_W-1:0]              f1_half_reg;
    bqe_pkg::color_t                        f1_color_reg;

    logic                                   f2_valid_reg;
    bqe_pkg::pos_t [2:0]                    f2_pos_reg;
    bqe_pkg::color_t                        f2_color_reg;
    logic signed [bqe_pkg::PROD_W-1:0]      prod_r_reg [3];
    logic signed [bqe_pkg::PROD_W-1:0]      prod_u_reg [3];

    logic signed [bqe_pkg::PROD_W-1:0]      prod_r_next [3];
    logic signed [bqe_pkg::PROD_W-1:0]      prod_u_next [3];
    logic signed [bqe_pkg::PROD_W-1:0]      neg_r [3];
    logic signed [bqe_pkg::PROD_W-1:0]      neg_u [3];

    logic f_adv;
    logic f1_load;
    logic keep;

    assign f_adv    = !(f2_valid_reg && q_full);
    assign in_stall = f1_valid_reg && !f_adv;
    assign f1_load  = f_adv || !f1_valid_reg;
    assign keep     = (opacity != '0) && (quad_size > 32'sd0);
    assign q_push   = f2_valid_reg && !q_full;

    // Stage 1: capture, drop invisible particles right away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (f1_load)
        begin
            f1_valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_load && in_valid)
        begin
            f1_pos_reg[0]         <= pos_x;
            f1_pos_reg[1]         <= pos_y;
            f1_pos_reg[2]         <= pos_z;
            f1_half_reg           <= {1'b0, quad_size[bqe_pkg::POS_W-1:1]};
            f1_color_reg.red      <= red;
            f1_color_reg.green    <= green;
            f1_color_reg.blue     <= blue;
            f1_color_reg.opacity  <= opacity;
            f1_color_reg.additive <= additive;
        end
    end

    // Stage 2: axis coefficient times half size
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_r_next[a] = bqe_pkg::PROD_W'($signed(coefs.right[a]))
                           * bqe_pkg::PROD_W'($signed(f1_half_reg));
            prod_u_next[a] = bqe_pkg::PROD_W'($signed(coefs.up[a]))
                           * bqe_pkg::PROD_W'($signed(f1_half_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_valid_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv && f1_valid_reg)
        begin
            f2_pos_reg   <= f1_pos_reg;
            f2_color_reg <= f1_color_reg;
            for (int a = 0; a < 3; a++)
            begin
                prod_r_reg[a] <= prod_r_next[a];
                prod_u_reg[a] <= prod_u_next[a];
            end
        end
    end

    // Floor shift of both signs; the negative corner is not a plain negation
    always_comb
    begin
        q_data.pos   = f2_pos_reg;
        q_data.color = f2_color_reg;
        for (int a = 0; a < 3; a++)
        begin
            neg_r[a] = -prod_r_reg[a];
            neg_u[a] = -prod_u_reg[a];
            q_data.right_pos[a] =
                prod_r_reg[a][bqe_pkg::TERM_W+bqe_pkg::FRAC_SHIFT-1:bqe_pkg::FRAC_SHIFT];
            q_data.right_neg[a] =
                neg_r[a][bqe_pkg::TERM_W+bqe_pkg::FRAC_SHIFT-1:bqe_pkg::FRAC_SHIFT];
            q_data.up_pos[a] =
                prod_u_reg[a][bqe_pkg::TERM_W+bqe_pkg::FRAC_SHIFT-1:bqe_pkg::FRAC_SHIFT];
            q_data.up_neg[a] =
                neg_u[a][bqe_pkg::TERM_W+bqe_pkg::FRAC_SHIFT-1:bqe_pkg::FRAC_SHIFT];
        end
    end

endmodule

### rtl/bqe_queue.sv
// Short queue of prepared quads between the front end and the vertex back end.
`timescale 1ns / 1ps

module bqe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bqe_pkg::quad_t      wr_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output bqe_pkg::quad_t      rd_data
);

    bqe_pkg::quad_t                 mem [bqe_pkg::QDEPTH];
    logic [bqe_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bqe_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [bqe_pkg::QCNT_W-1:0]     count_reg;
    logic [bqe_pkg::QCNT_W-1:0]     count_next;

    assign full      = (count_reg == bqe_pkg::QCNT_W'(bqe_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/bqe_back.sv
// Back end: walks the six corners of each quad and transforms them to clip space.
`timescale 1ns / 1ps

module bqe_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bqe_pkg::coef_set_t      coefs,
    input  logic                    q_valid,
    input  bqe_pkg::quad_t          q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      clip_x,
    output logic signed [31:0]      clip_y,
    output logic signed [31:0]      clip_z,
    output logic signed [31:0]      clip_w,
    output logic [15:0]             out_red,
    output logic [15:0]             out_green,
    output logic [15:0]             out_blue,
    output logic [15:0]             out_opacity,
    output logic [1:0]              corner_signs,
    output logic                    out_additive,
    output logic                    last_vertex
);

    logic [bqe_pkg::CORNER_W-1:0]           corner_reg;
    logic [1:0]                             signs_now;

    logic                                   b1_valid_reg;
    logic signed [bqe_pkg::WORLD_W-1:0]     world_reg [3];
    logic signed [bqe_pkg::WORLD_W-1:0]     world_next [3];
    bqe_pkg::color_t                        b1_color_reg;
    logic [1:0]                             b1_signs_reg;
    logic                                   b1_last_reg;

    logic                                   b2_valid_reg;
    logic signed [bqe_pkg::MPROD_W-1:0]     mprod_reg [4][3];
    bqe_pkg::color_t                        b2_color_reg;
    logic [1:0]                             b2_signs_reg;
    logic                                   b2_last_reg;

    logic                                   out_valid_reg;
    logic signed [bqe_pkg::POS_W-1:0]       clip_reg [4];
    logic signed [bqe_pkg::POS_W-1:0]       clip_next [4];
    logic signed [bqe_pkg::SUM_W-1:0]       sum [4];
    bqe_pkg::color_t                        out_color_reg;
    logic [1:0]                             out_signs_reg;
    logic                                   out_last_reg;

    logic adv;
    logic issue;

    // Whole back pipeline holds while a finished word waits
    assign adv       = !(out_valid_reg && out_stall);
    assign issue     = adv && q_valid;
    assign q_pop     = issue && (corner_reg == bqe_pkg::LAST_CORNER);
    assign signs_now = bqe_pkg::corner_code(corner_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
        end
        else if (issue)
        begin
            corner_reg <= (corner_reg == bqe_pkg::LAST_CORNER) ? '0 : corner_reg + 1'b1;
        end
    end

    // World point of the current corner
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            world_next[a] = bqe_pkg::WORLD_W'($signed(q_data.pos[a]))
                + (signs_now[0] ? bqe_pkg::WORLD_W'($signed(q_data.right_pos[a]))
                                : bqe_pkg::WORLD_W'($signed(q_data.right_neg[a])))
                + (signs_now[1] ? bqe_pkg::WORLD_W'($signed(q_data.up_pos[a]))
                                : bqe_pkg::WORLD_W'($signed(q_data.up_neg[a])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            for (int a = 0; a < 3; a++)
            begin
                world_reg[a] <= world_next[a];
            end
            b1_color_reg <= q_data.color;
            b1_signs_reg <= signs_now;
            b1_last_reg  <= (corner_reg == bqe_pkg::LAST_CORNER);
        end
    end

    // Matrix products, one per row and column
    always_ff @(posedge clk)
    begin
        if (adv && b1_valid_reg)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    mprod_reg[r][c] <=
                        bqe_pkg::MPROD_W'($signed(coefs.mat[4*r+c]))
                        * bqe_pkg::MPROD_W'(world_reg[c]);
                end
            end
            b2_color_reg <= b1_color_reg;
            b2_signs_reg <= b1_signs_reg;
            b2_last_reg  <= b1_last_reg;
        end
    end

    // Row sums with the w term, then clamp to 32 bits
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum[r] = bqe_pkg::SUM_W'($signed(coefs.mat[4*r+3])) <<< bqe_pkg::W_SHIFT;
            for (int c = 0; c < 3; c++)
            begin
                sum[r] = sum[r] + bqe_pkg::SUM_W'($signed(
                    mprod_reg[r][c][bqe_pkg::MPROD_W-1:bqe_pkg::FRAC_SHIFT]));
            end
            if (sum[r] > bqe_pkg::SAT_HI)
            begin
                clip_next[r] = bqe_pkg::SAT_HI[bqe_pkg::POS_W-1:0];
            end
            else if (sum[r] < bqe_pkg::SAT_LO)
            begin
                clip_next[r] = bqe_pkg::SAT_LO[bqe_pkg::POS_W-1:0];
            end
            else
            begin
                clip_next[r] = sum[r][bqe_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b2_valid_reg)
        begin
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= clip_next[r];
            end
            out_color_reg <= b2_color_reg;
            out_signs_reg <= b2_signs_reg;
            out_last_reg  <= b2_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign clip_x       = clip_reg[0];
    assign clip_y       = clip_reg[1];
    assign clip_z       = clip_reg[2];
    assign clip_w       = clip_reg[3];
    assign out_red      = out_color_reg.red;
    assign out_green    = out_color_reg.green;
    assign out_blue     = out_color_reg.blue;
    assign out_opacity  = out_color_reg.opacity;
    assign out_additive = out_color_reg.additive;
    assign corner_signs = out_signs_reg;
    assign last_vertex  = out_last_reg;

endmodule

### rtl/billboard_quad_expander.sv
// Top level: coefficient registers and the front, queue and back of the quad expander.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   pos_x pos_y pos_z quad_size color additive
//  out      output     out_valid / out_stall clip_x..clip_w color corner_signs last_vertex
//  cfg      input      cfg_valid / cfg_ready cfg_index cfg_data
//
// A kept particle yields six vertices, one per cycle while out_stall is low; the back end
// thus sets the rate, and a dropped particle is taken at the input but yields nothing.
// An accepted particle passes the f1, f2, queue, b1, b2 and output registers in turn.
// The four-entry queue lets particles be taken while vertices of earlier ones drain.
// Reset clears the coefficients, the queue and all valid flags; cfg_ready is always high.
// out_stall holds the whole back pipeline; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module billboard_quad_expander (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [62:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  quad_size,
    input  logic [15:0]         red,
    input  logic [15:0]         green,
    input  logic [15:0]         blue,
    input  logic [15:0]         opacity,
    input  logic                additive,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  clip_x,
    output logic signed [31:0]  clip_y,
    output logic signed [31:0]  clip_z,
    output logic signed [31:0]  clip_w,
    output logic [15:0]         out_red,
    output logic [15:0]         out_green,
    output logic [15:0]         out_blue,
    output logic [15:0]         out_opacity,
    output logic [1:0]          corner_signs,
    output logic                out_additive,
    output logic                last_vertex
);

    logic [bqe_pkg::CFG_W-1:0]  coef_reg [bqe_pkg::NUM_WORDS];
    bqe_pkg::coef_t             slot_val [bqe_pkg::NUM_SLOTS];
    bqe_pkg::coef_set_t         coefs;

    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_not_empty;
    bqe_pkg::quad_t             q_wr_data;
    bqe_pkg::quad_t             q_rd_data;

    assign cfg_ready = 1'b1;

    // Indexes past the last word are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bqe_pkg::NUM_WORDS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < bqe_pkg::CFG_IDX_W'(bqe_pkg::NUM_WORDS)))
        begin
            coef_reg[cfg_index[bqe_pkg::WORD_IDX_W-1:0]] <= cfg_data;
        end
    end

    for (genvar s = 0; s < bqe_pkg::NUM_SLOTS; s++)
    begin : g_slot
        localparam int WORD = s / bqe_pkg::SLOTS_PER_WORD;
        localparam int LSB  = (s % bqe_pkg::SLOTS_PER_WORD) * bqe_pkg::COEF_W;
        assign slot_val[s] = coef_reg[WORD][LSB +: bqe_pkg::COEF_W];
    end

    always_comb
    begin
        for (int s = 0; s < bqe_pkg::MAT_SLOTS; s++)
        begin
            coefs.mat[s] = slot_val[s];
        end
        for (int a = 0; a < 3; a++)
        begin
            coefs.right[a] = slot_val[bqe_pkg::RIGHT_SLOT + a];
            coefs.up[a]    = slot_val[bqe_pkg::UP_SLOT + a];
        end
    end

    bqe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .quad_size  (quad_size),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .opacity    (opacity),
        .additive   (additive),
        .coefs      (coefs),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    bqe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_data    (q_wr_data),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .rd_data    (q_rd_data)
    );

    bqe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .coefs        (coefs),
        .q_valid      (q_not_empty),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .clip_x       (clip_x),
        .clip_y       (clip_y),
        .clip_z       (clip_z),
        .clip_w       (clip_w),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_opacity  (out_opacity),
        .corner_signs (corner_signs),
        .out_additive (out_additive),
        .last_vertex  (last_vertex)
    );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the billboard quad expander: random particles against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int FRAC_BITS      = 12;
    localparam int ITEMS_A_PHASE  = 56;
    localparam int RANDOM_PHASES  = 8;
    localparam int LONG_HOLD_PHASE = 2;

    localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] P_MIN = 32'h8000_0000;
    localparam logic [31:0] P_ONE = 32'h0001_0000;

    localparam logic [20:0] COEF_ONE = 21'h001000;
    localparam logic [20:0] COEF_MAX = 21'h0FFFFF;
    localparam logic [20:0] COEF_MIN = 21'h100000;
    localparam logic [20:0] COEF_NEG_LSB = 21'h1FFFFF;

    // register indexes past the last coefficient word
    localparam logic [bqe_pkg::CFG_IDX_W-1:0] BAD_INDEX_LO = 4'd8;
    localparam logic [bqe_pkg::CFG_IDX_W-1:0] BAD_INDEX_HI = 4'd15;

    // corner order, bit0 = u positive, bit1 = v positive
    localparam logic [1:0] CORNER_ORDER [6] = '{2'b00, 2'b01, 2'b11, 2'b00, 2'b11, 2'b10};

    typedef enum int {COEF_FULL, COEF_MODERATE, COEF_EXTREME, COEF_ZERO, COEF_ALL_ONES} coef_mix_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic [15:0]        opacity;
        logic               additive;
    } particle_t;

    typedef struct packed {
        logic [31:0] clip_x;
        logic [31:0] clip_y;
        logic [31:0] clip_z;
        logic [31:0] clip_w;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] opacity;
        logic [1:0]  corner;
        logic        additive;
        logic        last;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bqe_pkg::CFG_W-1:0]     cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z, quad_size;
    logic [15:0] red, green, blue, opacity;
    logic additive;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] clip_x, clip_y, clip_z, clip_w;
    logic [15:0] out_red, out_green, out_blue, out_opacity;
    logic [1:0] corner_signs;
    logic out_additive;
    logic last_vertex;

    particle_t drive_item;
    particle_t particle_queue [$];
    vertex_t   expected_vertices [$];
    logic [bqe_pkg::CFG_W-1:0] coef_words [bqe_pkg::NUM_WORDS] = '{default: '0};
    logic [bqe_pkg::CFG_W-1:0] coef_plan [bqe_pkg::NUM_WORDS];

    int particles_queued  = 0;
    int particles_offered = 0;
    int particles_taken   = 0;
    int mismatches        = 0;
    int idle_cycles       = 0;
    int send_gap          = 0;
    int hold_left         = 0;
    int long_hold_reqs    = 0;
    int long_holds_done   = 0;
    bit sender_burst      = 1'b0;
    bit receiver_burst    = 1'b0;

    assign pos_x     = drive_item.pos_x;
    assign pos_y     = drive_item.pos_y;
    assign pos_z     = drive_item.pos_z;
    assign quad_size = drive_item.size;
    assign red       = drive_item.red;
    assign green     = drive_item.green;
    assign blue      = drive_item.blue;
    assign opacity   = drive_item.opacity;
    assign additive  = drive_item.additive;

    billboard_quad_expander dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .quad_size    (quad_size),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .opacity      (opacity),
        .additive     (additive),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .clip_x       (clip_x),
        .clip_y       (clip_y),
        .clip_z       (clip_z),
        .clip_w       (clip_w),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_opacity  (out_opacity),
        .corner_signs (corner_signs),
        .out_additive (out_additive),
        .last_vertex  (last_vertex)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint coef_of(input int slot);
        logic signed [20:0] c;
        c = coef_words[slot / 3][21 * (slot % 3) +: 21];
        return c;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return P_MAX;
        if (v < -64'sd2147483648)
            return P_MIN;
        return v[31:0];
    endfunction

    function automatic void expand_particle(input particle_t p);
        longint half, hu, hv, acc;
        longint pos [3];
        longint world [3];
        logic [31:0] clip [4];
        vertex_t vtx;
        int k, a, r, c;
        if (p.opacity == 16'h0 || p.size <= 0)
            return;
        pos[0] = p.pos_x;
        pos[1] = p.pos_y;
        pos[2] = p.pos_z;
        half = longint'(p.size) >>> 1;
        for (k = 0; k < 6; k++)
        begin
            hu = CORNER_ORDER[k][0] ? half : -half;
            hv = CORNER_ORDER[k][1] ? half : -half;
            for (a = 0; a < 3; a++)
                world[a] = pos[a]
                         + ((coef_of(bqe_pkg::RIGHT_SLOT + a) * hu) >>> FRAC_BITS)
                         + ((coef_of(bqe_pkg::UP_SLOT + a) * hv) >>> FRAC_BITS);
            for (r = 0; r < 4; r++)
            begin
                // w = 1 term: Q8.12 to Q16.16
                acc = coef_of(4 * r + 3) * 16;
                for (c = 0; c < 3; c++)
                    acc += (coef_of(4 * r + c) * world[c]) >>> FRAC_BITS;
                clip[r] = clamp32(acc);
            end
            vtx.clip_x   = clip[0];
            vtx.clip_y   = clip[1];
            vtx.clip_z   = clip[2];
            vtx.clip_w   = clip[3];
            vtx.red      = p.red;
            vtx.green    = p.green;
            vtx.blue     = p.blue;
            vtx.opacity  = p.opacity;
            vtx.corner   = CORNER_ORDER[k];
            vtx.additive = p.additive;
            vtx.last     = (k == 5);
            expected_vertices.insert(expected_vertices.size(), vtx);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_pos();
        case ($urandom_range(0, 9))
            0:       return P_MAX;
            1:       return P_MIN;
            2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        int r;
        p.pos_x = random_pos();
        p.pos_y = random_pos();
        p.pos_z = random_pos();
        r = $urandom_range(0, 99);
        if (r < 60)
            p.size = $urandom_range(1, 32'h0010_0000);
        else if (r < 80)
            p.size = $urandom_range(1, 32'h7FFF_FFFF);
        else if (r < 84)
            p.size = P_MAX;
        else if (r < 87)
            p.size = 1;
        else if (r < 93)
            p.size = $urandom;
        else if (r < 96)
            p.size = 0;
        else
            p.size = {1'b1, 31'($urandom)};
        p.red      = 16'($urandom);
        p.green    = 16'($urandom);
        p.blue     = 16'($urandom);
        p.opacity  = ($urandom_range(0, 99) < 7) ? 16'h0 : 16'($urandom);
        p.additive = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic particle_t make_particle(input logic [31:0] px, py, pz, sz,
                                                input logic [15:0] r, g, b, a,
                                                input logic add);
        particle_t p;
        p = '{px, py, pz, sz, r, g, b, a, add};
        return p;
    endfunction

    function automatic logic [20:0] random_slot(input coef_mix_t mix);
        case (mix)
            COEF_FULL:     return 21'($urandom);
            COEF_MODERATE: return 21'($urandom_range(0, 16384) - 8192);
            COEF_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_NEG_LSB;
                    3:       return COEF_ONE;
                    default: return 21'h0;
                endcase
            end
            COEF_ALL_ONES: return COEF_NEG_LSB;
            default:       return 21'h0;
        endcase
    endfunction

    function automatic void put_slot(input int slot, input logic [20:0] v);
        coef_plan[slot / 3][21 * (slot % 3) +: 21] = v;
    endfunction

    function automatic void queue_particle(input particle_t p);
        particle_queue.insert(particle_queue.size(), p);
        particles_queued++;
    endfunction

    task automatic write_coef(input logic [bqe_pkg::CFG_IDX_W-1:0] idx,
                              input logic [bqe_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_plan();
        int w;
        for (w = 0; w < bqe_pkg::NUM_WORDS; w++)
            write_coef(w[bqe_pkg::CFG_IDX_W-1:0], coef_plan[w]);
    endtask

    // wait for every queued particle to go in and every vertex to come out
    task automatic settle();
        while (particles_taken != particles_queued || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- driver side

    always @(negedge clk)
    begin : drive_particles
        bit done;
        done = in_valid && (particles_taken == particles_offered);
        if (rst_n)
        begin
            if (done)
                send_gap = pick_gap(sender_burst);
            if (!in_valid || done)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (particle_queue.size() != 0)
                begin
                    drive_item = particle_queue.pop_front();
                    particles_offered++;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (long_hold_reqs != long_holds_done)
            begin
                long_holds_done++;
                hold_left = $urandom_range(200, 260);
            end
            else if (hold_left == 0 && !receiver_burst && $urandom_range(0, 3) == 0)
            begin
                hold_left = pick_gap(1'b0);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- sampling side

    always @(posedge clk)
    begin : take_particle
        if (rst_n && in_valid && !in_stall)
        begin
            particles_taken++;
            expand_particle(drive_item);
        end
    end

    always @(posedge clk)
    begin : mirror_coefs
        if (rst_n && cfg_valid && cfg_ready && cfg_index < bqe_pkg::NUM_WORDS)
            coef_words[cfg_index[bqe_pkg::WORD_IDX_W-1:0]] = cfg_data;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_vertex
        vertex_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: vertex with nothing expected, clip %0h %0h %0h %0h",
                         $time, clip_x, clip_y, clip_z, clip_w);
                mismatches++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                check_field("clip_x", want.clip_x, clip_x);
                check_field("clip_y", want.clip_y, clip_y);
                check_field("clip_z", want.clip_z, clip_z);
                check_field("clip_w", want.clip_w, clip_w);
                check_field("out_red", want.red, out_red);
                check_field("out_green", want.green, out_green);
                check_field("out_blue", want.blue, out_blue);
                check_field("out_opacity", want.opacity, out_opacity);
                check_field("corner_signs", want.corner, corner_signs);
                check_field("out_additive", want.additive, out_additive);
                check_field("last_vertex", want.last, last_vertex);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** billboard_quad_expander: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin : run_test
        int ph, n, slot, k;
        coef_mix_t mix;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        drive_item = '{default: '0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity matrix, right along x, up along y
        coef_plan = '{default: '0};
        for (k = 0; k < 4; k++)
            put_slot(5 * k, COEF_ONE);
        put_slot(bqe_pkg::RIGHT_SLOT, COEF_ONE);
        put_slot(bqe_pkg::UP_SLOT + 1, COEF_ONE);
        write_plan();
        // out-of-range indexes must leave the coefficients alone
        write_coef(BAD_INDEX_LO, 63'({$urandom, $urandom}));
        write_coef(BAD_INDEX_HI, '1);

        queue_particle(make_particle(0, 0, 0, 2 * P_ONE, 0, 0, 0, 16'hFFFF, 0));
        queue_particle(make_particle(P_MAX, P_MAX, P_MAX, P_MAX,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        queue_particle(make_particle(P_MIN, P_MIN, P_MIN, 1, 0, 0, 0, 16'h0001, 0));
        queue_particle(make_particle(P_ONE, -P_ONE, 5 * P_ONE, 3 * P_ONE,
                                     16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 1));
        queue_particle(make_particle(P_ONE, P_ONE, P_ONE, 0, 1, 2, 3, 16'h00FF, 0));
        queue_particle(make_particle(P_ONE, P_ONE, P_ONE, 32'hFFFF_FFFF, 1, 2, 3, 16'h00FF, 1));
        queue_particle(make_particle(P_ONE, P_ONE, P_ONE, P_MIN, 1, 2, 3, 16'h00FF, 0));
        queue_particle(make_particle(P_MIN, P_MAX, 0, 2, 16'h00FF, 16'hFF00, 16'h8000,
                                     16'h0100, 1));
        queue_particle(make_particle(P_MAX, P_MIN, 32'hFFFF_FFFF, P_MAX,
                                     16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE, 0));
        queue_particle(make_particle(-3 * P_ONE, 7 * P_ONE, P_ONE >> 1, P_ONE,
                                     16'h8000, 16'h00FF, 16'hFF00, 16'h0100, 1));
        queue_particle(make_particle(32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_0F0F, 32'h0000_FFFF,
                                     16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 0));
        queue_particle(make_particle(32'hAAAA_5555, 32'h5555_AAAA, 32'hF0F0_F0F0, 3,
                                     16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 1));
        settle();

        // every slot at the top, then at the bottom of its range: drives saturation
        for (n = 0; n < 2; n++)
        begin
            for (slot = 0; slot < 3 * bqe_pkg::NUM_WORDS; slot++)
                put_slot(slot, (n == 0) ? COEF_MAX : COEF_MIN);
            write_plan();
            queue_particle(make_particle(P_MAX, P_MAX, P_MAX, P_MAX,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
            queue_particle(make_particle(P_MIN, P_MIN, P_MIN, P_MAX, 0, 0, 0, 16'h0001, 0));
            queue_particle(make_particle(P_MAX, P_MIN, P_MAX, P_MAX, 1, 1, 1, 16'h8000, 1));
            queue_particle(make_particle(0, 0, 0, P_MAX, 2, 2, 2, 16'h0002, 0));
            queue_particle(make_particle(P_MIN, P_MAX, 0, 1, 3, 3, 3, 16'h7FFF, 1));
            settle();
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mix = coef_mix_t'(ph % 4);
            if (ph == RANDOM_PHASES - 1)
                mix = COEF_ALL_ONES;
            for (slot = 0; slot < 3 * bqe_pkg::NUM_WORDS; slot++)
                put_slot(slot, random_slot(mix));
            write_plan();
            if ($urandom_range(0, 1) == 1)
                write_coef(4'($urandom_range(8, 15)), 63'({$urandom, $urandom}));
            sender_burst   = (ph % 3 == 1) || (ph == LONG_HOLD_PHASE);
            receiver_burst = (ph % 3 == 2) || (ph == 4);
            // hold the output long enough for the input to back up
            if (ph == LONG_HOLD_PHASE)
                long_hold_reqs++;
            for (n = 0; n < ITEMS_A_PHASE; n++)
                queue_particle(random_particle());
            settle();
        end

        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("** billboard_quad_expander: PASSED **");
        else
            $display("** billboard_quad_expander: FAILED **");
        $finish;
    end

endmodule
